// ===== sv/bsi_pkg.sv =====
// shared constants, types and breakpoint tables for the state-of-charge interpolator
// no dependencies
package bsi_pkg;

   localparam int VOLT_W = 16;
   localparam int PCT_W = 15;
   localparam int SEG_W = 4;
   localparam int NUM_W = 27;
   localparam int QUO_W = 12;
   localparam int REM_W = 16;
   localparam int CNT_W = 4;

   localparam logic [SEG_W-1:0] FIRST_SEG = 4'd1;
   localparam logic [SEG_W-1:0] LAST_POINT = 4'd10;
   localparam logic [CNT_W-1:0] LAST_STEP = 4'(QUO_W - 1);
   localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;

   typedef struct packed {
      logic done;
      logic sat;
      logic [SEG_W-1:0] seg;
   } search_status_type;

   function automatic logic [VOLT_W-1:0] point_volt(input logic [SEG_W-1:0] k);
      logic [VOLT_W-1:0] v;
      unique case (k)
         4'd0: v = 16'd0;
         4'd1: v = 16'd34585;
         4'd2: v = 16'd35525;
         4'd3: v = 16'd36011;
         4'd4: v = 16'd36470;
         4'd5: v = 16'd37261;
         4'd6: v = 16'd38302;
         4'd7: v = 16'd39118;
         4'd8: v = 16'd39995;
         4'd9: v = 16'd40823;
         4'd10: v = 16'd41607;
         default: v = 16'd41607;
      endcase
      return v;
   endfunction

   // percentage at the lower end of segment k
   function automatic logic [PCT_W-1:0] seg_base(input logic [SEG_W-1:0] k);
      logic [PCT_W-1:0] p;
      unique case (k)
         4'd1: p = 15'd0;
         4'd2: p = 15'd2560;
         4'd3: p = 15'd5120;
         4'd4: p = 15'd7680;
         4'd5: p = 15'd10240;
         4'd6: p = 15'd12800;
         4'd7: p = 15'd15360;
         4'd8: p = 15'd17920;
         4'd9: p = 15'd20480;
         4'd10: p = 15'd23040;
         default: p = 15'd0;
      endcase
      return p;
   endfunction

endpackage

// ===== sv/battery_soc_interpolator.sv =====
// Converts a cell voltage (0.1 mV units) into state of charge in percent with 8 fraction
// bits, by piecewise linear interpolation over an 11-point curve. A request is taken
// when start is high and busy is low; busy then stays high until the result strobe.
// The breakpoint search visits one breakpoint per cycle, then the serial divider
// produces the 12-bit quotient one bit at a time and raises its done flag, and the
// result is registered with the strobe; a voltage at or above full charge skips the
// divider. rsp_valid is high for exactly one cycle with rsp_charge_percent; the receiver
// cannot stall it, so it must take the result then.
// depends on bsi_pkg, bsi_search, bsi_divider
module battery_soc_interpolator (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [15:0] req_cell_voltage,
   output logic rsp_valid,
   output logic [14:0] rsp_charge_percent
);
   import bsi_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [VOLT_W-1:0] v_ff, v_in;
   logic [PCT_W-1:0] base_ff, base_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0] pct_ff, pct_in;

   logic accept;
   search_status_type status;
   logic div_start;
   logic div_done;
   logic [QUO_W-1:0] quotient;
   logic [VOLT_W-1:0] vlo;
   logic [REM_W-1:0] span;
   logic [VOLT_W-1:0] delta;
   logic [NUM_W-1:0] dividend;

   assign accept = start && !busy;
   assign busy = state_ff != ST_IDLE;

   assign vlo = point_volt(status.seg - 4'd1);
   assign span = point_volt(status.seg) - vlo;
   assign delta = v_ff - vlo;
   // times 2560 as two shifts
   assign dividend = {delta, 11'd0} + {2'd0, delta, 9'd0};
   assign div_start = (state_ff == ST_SEARCH) && status.done && !status.sat;

   bsi_search u_search (
      .clock(clock),
      .reset(reset),
      .start(accept),
      .voltage(req_cell_voltage),
      .status(status)
   );

   bsi_divider u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(dividend),
      .divisor(span),
      .done(div_done),
      .quotient(quotient)
   );

   always_comb begin
      state_in = state_ff;
      v_in = v_ff;
      base_in = base_ff;
      rsp_valid_in = 1'b0;
      pct_in = pct_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               v_in = req_cell_voltage;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.done) begin
               if (status.sat) begin
                  rsp_valid_in = 1'b1;
                  pct_in = PCT_FULL;
                  state_in = ST_IDLE;
               end else begin
                  base_in = seg_base(status.seg);
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               pct_in = base_ff + {3'd0, quotient};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff <= v_in;
      base_ff <= base_in;
      pct_ff <= pct_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_charge_percent = pct_ff;

`ifndef SYNTHESIS
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_charge_percent <= PCT_FULL))
      else $error("charge percent above full scale");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after request");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside divide phase");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");
`endif

endmodule

// ===== sv/bsi_search.sv =====
// breakpoint sequencer: walks the voltage curve one breakpoint per cycle
// depends on bsi_pkg
module bsi_search (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [bsi_pkg::VOLT_W-1:0] voltage,
   output bsi_pkg::search_status_type status
);
   import bsi_pkg::*;

   logic running_ff, running_in;
   logic [SEG_W-1:0] k_ff, k_in;
   logic [VOLT_W-1:0] v_ff, v_in;
   logic ge;
   logic advance;

   assign ge = v_ff >= point_volt(k_ff);
   assign advance = ge && (k_ff != LAST_POINT);

   always_comb begin
      running_in = running_ff;
      k_in = k_ff;
      v_in = v_ff;
      if (start) begin
         running_in = 1'b1;
         k_in = FIRST_SEG;
         v_in = voltage;
      end else if (running_ff) begin
         if (advance) begin
            k_in = k_ff + 4'd1;
         end else begin
            running_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
      end
      k_ff <= k_in;
      v_ff <= v_in;
   end

   assign status.done = running_ff && !advance;
   assign status.sat = ge;
   assign status.seg = k_ff;

endmodule

// ===== sv/bsi_divider.sv =====
// restoring divider, one quotient bit per cycle through a shift register
// depends on bsi_pkg
module bsi_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [bsi_pkg::NUM_W-1:0] dividend,
   input  logic [bsi_pkg::REM_W-1:0] divisor,
   output logic done,
   output logic [bsi_pkg::QUO_W-1:0] quotient
);
   import bsi_pkg::*;

   logic running_ff, running_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0] div_ff, div_in;
   logic [REM_W:0] trial;
   logic [REM_W:0] diff;
   logic fits;

   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign diff = trial - {1'b0, div_ff};
   assign fits = trial >= {1'b0, div_ff};

   always_comb begin
      running_in = running_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      if (start) begin
         running_in = 1'b1;
         cnt_in = '0;
         // quotient stays below 2^12, so the high part is already below the divisor
         rem_in = {1'b0, dividend[NUM_W-1:QUO_W]};
         quo_in = dividend[QUO_W-1:0];
         div_in = divisor;
      end else if (running_ff) begin
         rem_in = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == LAST_STEP) begin
            running_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         running_ff <= running_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> !done_ff)
      else $error("divider done while still running");
   a_step_count: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (cnt_ff <= LAST_STEP))
      else $error("divider step count out of range");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");
`endif

endmodule

// ===== sim/tb_battery_soc_interpolator.sv =====
// self-checking testbench for battery_soc_interpolator: directed table, then random voltages
// checked against an in-bench model of the charge curve, with random idle gaps on the sender
// depends on bsi_pkg and battery_soc_interpolator
module tb_battery_soc_interpolator;
   timeunit 1ns;
   timeprecision 1ps;

   import bsi_pkg::*;

   localparam int RANDOM_REQUESTS = 1600;
   localparam int CALM_TAIL = 200;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int unsigned STEP_Q8 = 2560;

   typedef struct {
      logic [VOLT_W-1:0] volt;
      logic [PCT_W-1:0] charge;
   } charge_entry_type;

   typedef struct {
      logic [VOLT_W-1:0] volt;
      bit known;
      logic [PCT_W-1:0] charge;
   } directed_row_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [VOLT_W-1:0] req_cell_voltage;
   logic rsp_valid;
   logic [PCT_W-1:0] rsp_charge_percent;

   int unsigned curve_volt [0:10] = '{0, 34585, 35525, 36011, 36470, 37261,
                                      38302, 39118, 39995, 40823, 41607};

   charge_entry_type pending_q[$];
   directed_row_type directed_rows[$];
   int charge_mismatches = 0;
   int cycle_count = 0;

   battery_soc_interpolator uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cell_voltage(req_cell_voltage),
      .rsp_valid(rsp_valid),
      .rsp_charge_percent(rsp_charge_percent)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [PCT_W-1:0] predict_charge(input logic [VOLT_W-1:0] v);
      int unsigned volts;
      int unsigned seg;
      int unsigned lo;
      int unsigned hi;
      volts = v;
      if (volts == curve_volt[0]) return '0;
      if (volts >= curve_volt[10]) return PCT_FULL;
      seg = 1;
      while (seg < 10 && volts >= curve_volt[seg]) seg++;
      lo = curve_volt[seg - 1];
      hi = curve_volt[seg];
      return PCT_W'(STEP_Q8 * (seg - 1) + (STEP_Q8 * (volts - lo)) / (hi - lo));
   endfunction

   function automatic logic [VOLT_W-1:0] pick_voltage();
      int sel;
      int v;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         v = $urandom_range(curve_volt[1], curve_volt[10] - 1);
      end else if (sel < 80) begin
         v = curve_volt[$urandom_range(1, 10)] + $urandom_range(0, 6) - 3;
      end else if (sel < 85) begin
         v = $urandom_range(0, 15);
      end else begin
         v = $urandom_range(0, 65535);
      end
      return VOLT_W'(v);
   endfunction

   task automatic report_mismatch(input string what, input logic [VOLT_W-1:0] v,
                                  input logic [PCT_W-1:0] want, input logic [PCT_W-1:0] got);
      $display("[%0t] %s: voltage %0d expected %0d got %0d", $realtime, what, v, want, got);
      charge_mismatches++;
   endtask

   task automatic add_row(input logic [VOLT_W-1:0] v, input bit known,
                          input logic [PCT_W-1:0] c);
      directed_row_type row;
      row.volt = v;
      row.known = known;
      row.charge = c;
      directed_rows.push_back(row);
   endtask

   task automatic issue_request(input logic [VOLT_W-1:0] v, input logic [PCT_W-1:0] want);
      charge_entry_type entry;
      entry.volt = v;
      entry.charge = want;
      @(negedge clock);
      start <= 1'b1;
      req_cell_voltage <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_q.push_back(entry);
   endtask

   task automatic hold_off(input int n);
      @(negedge clock);
      start <= 1'b0;
      req_cell_voltage <= VOLT_W'($urandom_range(0, 65535));
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      charge_entry_type entry;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected result", 'x, 'x, rsp_charge_percent);
         end else begin
            entry = pending_q.pop_front();
            if (rsp_charge_percent !== entry.charge)
               report_mismatch("charge_percent", entry.volt, entry.charge, rsp_charge_percent);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      bit idle_on;
      logic [VOLT_W-1:0] v;
      int k;
      reset = 1'b1;
      start = 1'b0;
      req_cell_voltage = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero, full scale, every breakpoint, some of their neighbors and other voltages
      add_row(16'd0, 1'b1, 15'd0);
      add_row(16'd1, 1'b0, '0);
      add_row(16'd34584, 1'b0, '0);
      add_row(16'd34585, 1'b1, 15'd2560);
      add_row(16'd35525, 1'b1, 15'd5120);
      add_row(16'd36011, 1'b1, 15'd7680);
      add_row(16'd36470, 1'b1, 15'd10240);
      add_row(16'd37261, 1'b1, 15'd12800);
      add_row(16'd38302, 1'b1, 15'd15360);
      add_row(16'd39118, 1'b1, 15'd17920);
      add_row(16'd39995, 1'b1, 15'd20480);
      add_row(16'd40823, 1'b1, 15'd23040);
      add_row(16'd41606, 1'b0, '0);
      add_row(16'd41607, 1'b1, PCT_FULL);
      add_row(16'd41608, 1'b1, PCT_FULL);
      add_row(16'd65535, 1'b1, PCT_FULL);
      add_row(16'd32768, 1'b0, '0);
      add_row(16'd36010, 1'b0, '0);
      add_row(16'd38303, 1'b0, '0);
      add_row(16'd40822, 1'b0, '0);
      add_row(16'h5555, 1'b0, '0);
      add_row(16'haaaa, 1'b1, PCT_FULL);

      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].volt,
                       directed_rows[i].known ? directed_rows[i].charge
                                              : predict_charge(directed_rows[i].volt));
         if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 11));
      end
      wait_drained();

      idle_on = 1'b1;
      for (k = 0; k < RANDOM_REQUESTS; k++) begin
         if (k % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
         if (k == RANDOM_REQUESTS / 2) wait_drained();
         v = pick_voltage();
         issue_request(v, predict_charge(v));
         if (k < RANDOM_REQUESTS - CALM_TAIL && idle_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 11));
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (charge_mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/bsi_pkg.sv
sv/bsi_search.sv
sv/bsi_divider.sv
sv/battery_soc_interpolator.sv
sim/tb_battery_soc_interpolator.sv
